FILE: rtl/ascs_pkg.sv
// Types, constants and helpers for the ADC scan smoothing and calibration block.
// Used by every module of the block; no dependencies.
package ascs_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int BYTE_BITS   = 8;
    localparam int SLOW_SHIFT  = 6;
    localparam int FAST_SHIFT  = 2;
    localparam int ACC_BITS    = 16;
    localparam int CNT_BITS    = 16;
    localparam int SUM_BITS    = 26;
    localparam int QDEPTH      = 2;
    localparam int NUM_FILT    = 5;

    localparam logic [CNT_BITS-1:0] CAL_SCANS_RESET = 16'd256;

    // Filter channel slots
    localparam int CH_MOTOR = 0;
    localparam int CH_TEMP  = 1;
    localparam int CH_BATT  = 2;
    localparam int CH_THR   = 3;
    localparam int CH_BRK   = 4;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] phase_b_sample;
        logic [SAMPLE_BITS-1:0] motor_current_sample;
        logic [SAMPLE_BITS-1:0] temperature_sample;
        logic [SAMPLE_BITS-1:0] battery_sample;
        logic [BYTE_BITS-1:0]   throttle_sample;
        logic [BYTE_BITS-1:0]   brake_sample;
    } t_scan;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] phase_b_raw;
        logic [SAMPLE_BITS-1:0] motor_current_raw;
        logic [SAMPLE_BITS-1:0] motor_current_smooth;
        logic [SAMPLE_BITS-1:0] temperature_smooth;
        logic [SAMPLE_BITS-1:0] battery_smooth;
        logic [BYTE_BITS-1:0]   throttle_smooth;
        logic [BYTE_BITS-1:0]   brake_smooth;
        logic [SAMPLE_BITS-1:0] phase_b_offset;
        logic [SAMPLE_BITS-1:0] motor_offset;
        logic                   calib_done;
        logic [CNT_BITS-1:0]    scan_count;
    } t_result;

    // Classified scan as it travels from front to back
    typedef struct packed {
        t_scan               scan;
        logic [CNT_BITS-1:0] scan_count;
        logic                cal;       // scan belongs to the calibration window
        logic                last;      // scan closes the calibration window
        logic [CNT_BITS-1:0] cal_cnt;   // scans summed including this one
    } t_qent;

    // Leaky accumulator update, wraps at ACC_BITS
    function automatic logic [ACC_BITS-1:0] leak_step(
        input logic [ACC_BITS-1:0]    acc,
        input logic [SAMPLE_BITS-1:0] smooth,
        input logic [SAMPLE_BITS-1:0] sample
    );
        return acc - ACC_BITS'(smooth) + ACC_BITS'(sample);
    endfunction

endpackage

FILE: rtl/adc_scan_smoothing_calibration.sv
// ADC scan smoothing and current-offset calibration, top level.
// Ties together ascs_front, ascs_fifo and ascs_back; depends on ascs_pkg.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_data carries one ADC scan per
//   transaction. Output channel o_out_valid / i_out_stall / o_out_data returns
//   one result per scan, in order. Config channel i_cfg_valid / o_cfg_ready /
//   i_cfg_data writes calib_scans (reset 256); write it only while idle.
//   An accepted scan is written into the queue; the back end pops it into the
//   result register when the output is free. Throughput: one scan per cycle
//   unless the output stalls or a division runs. The window-closing scan runs two
//   restoring dividers; its result follows both, and later scans queue behind it.
//   A two-entry queue decouples front and back; o_in_stall rises when it is full.
//   When i_out_stall is high the result register holds its transaction; the
//   back end stops and the queue fills, then the input stalls.
//   Reset (i_rst_n low, synchronous) clears filters, counters, sums, offsets,
//   calib_done and the queue, and restores calib_scans to 256. No clearing pass.
module adc_scan_smoothing_calibration (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ascs_pkg::t_scan               i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ascs_pkg::t_result             o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ascs_pkg::CNT_BITS-1:0] i_cfg_data
);
    import ascs_pkg::*;

    t_qent push_entry, head_entry;
    logic  push, pop, q_empty, q_full;

    assign o_in_stall = q_full;

    // Accept and classify
    ascs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_full      (q_full),
        .o_push      (push),
        .o_entry     (push_entry),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // Front-to-back queue
    ascs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Filters, calibration and result
    ascs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_entry),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/ascs_fifo.sv
// Short transaction queue between the front and back parts.
// Depends on ascs_pkg.
module ascs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ascs_pkg::t_qent i_entry,
    input  logic          i_pop,
    output ascs_pkg::t_qent o_head,
    output logic          o_empty,
    output logic          o_full
);
    import ascs_pkg::*;

    localparam int PTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W    = $clog2(QDEPTH + 1);

    t_qent               r_mem [QDEPTH];
    logic [PTR_BITS-1:0] r_wp, r_rp;
    logic [CNT_W-1:0]    r_cnt;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_BITS'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_BITS'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(QDEPTH));

endmodule

FILE: rtl/ascs_front.sv
// Front part: accepts scans, counts them and tags the calibration window.
// Holds the calib_scans register. Depends on ascs_pkg.
module ascs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  ascs_pkg::t_scan               i_in_data,
    input  logic                          i_full,
    output logic                          o_push,
    output ascs_pkg::t_qent               o_entry,
    input  logic                          i_cfg_valid,
    input  logic [ascs_pkg::CNT_BITS-1:0] i_cfg_data,
    output logic                          o_cfg_ready
);
    import ascs_pkg::*;

    logic [CNT_BITS-1:0] r_calib_scans;
    logic [CNT_BITS-1:0] r_scans;
    logic [CNT_BITS-1:0] r_cal_cnt;
    logic                r_cal_open;

    logic                accept;
    logic [CNT_BITS-1:0] cal_cnt_inc;
    logic                cal_last;

    assign accept      = i_in_valid && !i_full;
    assign cal_cnt_inc = r_cal_cnt + 1'b1;
    // Window closes once the count reaches or passes the register
    assign cal_last    = r_cal_open && (cal_cnt_inc >= r_calib_scans);

    assign o_push      = accept;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_entry.scan       = i_in_data;
        o_entry.scan_count = r_scans + 1'b1;
        o_entry.cal        = r_cal_open;
        o_entry.last       = cal_last;
        o_entry.cal_cnt    = cal_cnt_inc;
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_scans <= CAL_SCANS_RESET;
        end else if (i_cfg_valid) begin
            r_calib_scans <= i_cfg_data;
        end
    end

    // Scan and calibration counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scans    <= '0;
            r_cal_cnt  <= '0;
            r_cal_open <= 1'b1;
        end else if (accept) begin
            r_scans <= r_scans + 1'b1;
            if (r_cal_open) begin
                r_cal_cnt  <= cal_cnt_inc;
                r_cal_open <= !cal_last;
            end
        end
    end

endmodule

FILE: rtl/ascs_div.sv
// Restoring divider, one quotient bit per cycle, for the offset average.
// Depends on ascs_pkg.
module ascs_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ascs_pkg::SUM_BITS-1:0]    i_dividend,
    input  logic [ascs_pkg::CNT_BITS-1:0]    i_divisor,
    output logic                             o_done,
    output logic [ascs_pkg::SAMPLE_BITS-1:0] o_quotient
);
    import ascs_pkg::*;

    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_step;
    logic [CNT_BITS-1:0]  r_rem;
    logic [SUM_BITS-1:0]  r_quo;
    logic [CNT_BITS-1:0]  r_dsr;

    logic [CNT_BITS:0]    rem_sh;
    logic                 ge;

    // One restoring step; the remainder stays below the divisor
    assign rem_sh = {r_rem, r_quo[SUM_BITS-1]};
    assign ge     = (rem_sh >= {1'b0, r_dsr});

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? CNT_BITS'(rem_sh - {1'b0, r_dsr}) : rem_sh[CNT_BITS-1:0];
            r_quo <= {r_quo[SUM_BITS-2:0], ge};
        end
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_BITS'(SUM_BITS);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[SAMPLE_BITS-1:0];

endmodule

FILE: rtl/ascs_back.sv
// Back part: leaky filters, calibration sums, offset division and result register.
// Depends on ascs_pkg and ascs_div.
module ascs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ascs_pkg::t_qent   i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ascs_pkg::t_result o_out_data
);
    import ascs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_bstate;

    t_bstate                r_state;
    logic [ACC_BITS-1:0]    r_acc [NUM_FILT];
    logic [SAMPLE_BITS-1:0] r_sm  [NUM_FILT];
    logic [SAMPLE_BITS-1:0] r_raw_pb, r_raw_mc;
    logic [SUM_BITS-1:0]    r_sum_pb, r_sum_mc;
    logic [SAMPLE_BITS-1:0] r_off_pb, r_off_mc;
    logic                   r_done;
    logic [CNT_BITS-1:0]    r_scan_cnt;
    t_result                r_out;
    logic                   r_out_valid;

    logic [ACC_BITS-1:0]    n_acc [NUM_FILT];
    logic [SAMPLE_BITS-1:0] n_sm  [NUM_FILT];
    logic [SUM_BITS-1:0]    n_sum_pb, n_sum_mc;
    logic                   out_free;
    logic                   emit;
    logic                   div_done_pb, div_done_mc;
    logic [SAMPLE_BITS-1:0] quo_pb, quo_mc;
    t_result                res_now, res_held;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty && out_free;
    assign emit     = (r_state == S_EMIT) && out_free;

    // Filter updates
    always_comb begin
        n_acc[CH_MOTOR] = leak_step(r_acc[CH_MOTOR], r_sm[CH_MOTOR],
                                    i_head.scan.motor_current_sample);
        n_acc[CH_TEMP]  = leak_step(r_acc[CH_TEMP], r_sm[CH_TEMP],
                                    i_head.scan.temperature_sample);
        n_acc[CH_BATT]  = leak_step(r_acc[CH_BATT], r_sm[CH_BATT],
                                    i_head.scan.battery_sample);
        n_acc[CH_THR]   = leak_step(r_acc[CH_THR], r_sm[CH_THR],
                                    SAMPLE_BITS'(i_head.scan.throttle_sample));
        n_acc[CH_BRK]   = leak_step(r_acc[CH_BRK], r_sm[CH_BRK],
                                    SAMPLE_BITS'(i_head.scan.brake_sample));
        n_sm[CH_MOTOR]  = n_acc[CH_MOTOR][SLOW_SHIFT +: SAMPLE_BITS];
        n_sm[CH_TEMP]   = n_acc[CH_TEMP][SLOW_SHIFT +: SAMPLE_BITS];
        n_sm[CH_BATT]   = n_acc[CH_BATT][FAST_SHIFT +: SAMPLE_BITS];
        n_sm[CH_THR]    = SAMPLE_BITS'(n_acc[CH_THR][FAST_SHIFT +: BYTE_BITS]);
        n_sm[CH_BRK]    = SAMPLE_BITS'(n_acc[CH_BRK][FAST_SHIFT +: BYTE_BITS]);
    end

    // Calibration sums
    always_comb begin
        n_sum_pb = r_sum_pb;
        n_sum_mc = r_sum_mc;
        if (i_head.cal) begin
            n_sum_pb = r_sum_pb + SUM_BITS'(i_head.scan.phase_b_sample);
            n_sum_mc = r_sum_mc + SUM_BITS'(i_head.scan.motor_current_sample);
        end
    end

    // Result from this scan's fresh state
    always_comb begin
        res_now.phase_b_raw          = i_head.scan.phase_b_sample;
        res_now.motor_current_raw    = i_head.scan.motor_current_sample;
        res_now.motor_current_smooth = n_sm[CH_MOTOR];
        res_now.temperature_smooth   = n_sm[CH_TEMP];
        res_now.battery_smooth       = n_sm[CH_BATT];
        res_now.throttle_smooth      = n_sm[CH_THR][BYTE_BITS-1:0];
        res_now.brake_smooth         = n_sm[CH_BRK][BYTE_BITS-1:0];
        res_now.phase_b_offset       = r_off_pb;
        res_now.motor_offset         = r_off_mc;
        res_now.calib_done           = r_done;
        res_now.scan_count           = i_head.scan_count;
    end

    // Result of the window-closing scan, after the division
    always_comb begin
        res_held.phase_b_raw          = r_raw_pb;
        res_held.motor_current_raw    = r_raw_mc;
        res_held.motor_current_smooth = r_sm[CH_MOTOR];
        res_held.temperature_smooth   = r_sm[CH_TEMP];
        res_held.battery_smooth       = r_sm[CH_BATT];
        res_held.throttle_smooth      = r_sm[CH_THR][BYTE_BITS-1:0];
        res_held.brake_smooth         = r_sm[CH_BRK][BYTE_BITS-1:0];
        res_held.phase_b_offset       = r_off_pb;
        res_held.motor_offset         = r_off_mc;
        res_held.calib_done           = r_done;
        res_held.scan_count           = r_scan_cnt;
    end

    // Offset dividers, started on the window-closing scan
    ascs_div u_div_pb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (o_pop && i_head.last),
        .i_dividend (n_sum_pb),
        .i_divisor  (i_head.cal_cnt),
        .o_done     (div_done_pb),
        .o_quotient (quo_pb)
    );

    ascs_div u_div_mc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (o_pop && i_head.last),
        .i_dividend (n_sum_mc),
        .i_divisor  (i_head.cal_cnt),
        .o_done     (div_done_mc),
        .o_quotient (quo_mc)
    );

    // Filter and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FILT; i++) begin
                r_acc[i] <= '0;
                r_sm[i]  <= '0;
            end
            r_raw_pb   <= '0;
            r_raw_mc   <= '0;
            r_sum_pb   <= '0;
            r_sum_mc   <= '0;
            r_scan_cnt <= '0;
        end else if (o_pop) begin
            for (int i = 0; i < NUM_FILT; i++) begin
                r_acc[i] <= n_acc[i];
                r_sm[i]  <= n_sm[i];
            end
            r_raw_pb   <= i_head.scan.phase_b_sample;
            r_raw_mc   <= i_head.scan.motor_current_sample;
            r_sum_pb   <= n_sum_pb;
            r_sum_mc   <= n_sum_mc;
            r_scan_cnt <= i_head.scan_count;
        end
    end

    // Sequencer and offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_off_pb <= '0;
            r_off_mc <= '0;
            r_done   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_head.last) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done_pb && div_done_mc) begin
                        r_off_pb <= quo_pb;
                        r_off_mc <= quo_mc;
                        r_done   <= 1'b1;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (o_pop && !i_head.last) begin
            r_out <= res_now;
        end else if (emit) begin
            r_out <= res_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((o_pop && !i_head.last) || emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/ascs_checker.sv
// Port-level checks for adc_scan_smoothing_calibration, bound to the top level.
// Depends on ascs_pkg.
module ascs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input ascs_pkg::t_result o_out_data
);
    import ascs_pkg::*;

    logic r_seen_done;

    // Remember that a done result has been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_done <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_data.calib_done) begin
            r_seen_done <= 1'b1;
        end
    end

    // Stalled result stays valid and unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // No result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Calibration done never drops once delivered
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_done && o_out_valid |-> o_out_data.calib_done)
        else $error("calib_done dropped");

    // Offsets read zero until calibration completes
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.calib_done |->
            o_out_data.phase_b_offset == '0 && o_out_data.motor_offset == '0)
        else $error("offset nonzero before calibration done");

endmodule

bind adc_scan_smoothing_calibration ascs_checker u_ascs_checker (.*);

FILE: tb/tb_adc_scan_smoothing_calibration.sv
// Self-checking testbench for adc_scan_smoothing_calibration: random and directed ADC scans,
// an in-bench filter and calibration predictor, random idling on both channels.
// Depends on ascs_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_adc_scan_smoothing_calibration;
    import ascs_pkg::*;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_CYCLES    = 160;
    localparam int          HOLD_AT_RESULT = 600;
    localparam int          IDLE_PCT       = 18;
    localparam logic [9:0]  MAX10          = 10'h3FF;
    localparam logic [7:0]  MAX8           = 8'hFF;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_scan               in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_result             out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CNT_BITS-1:0] cfg_data = '0;

    // Stimulus and expected-result stores
    t_scan       pending_scans[$];
    t_result     expected_results[$];
    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned n_errors   = 0;
    int unsigned quiet_cycles = 0;

    // Predictor state
    logic [CNT_BITS-1:0] calib_target;
    logic [ACC_BITS-1:0] filt_acc[NUM_FILT];
    logic [9:0]          filt_out[NUM_FILT];
    logic [CNT_BITS-1:0] scans_total;
    logic [SUM_BITS-1:0] sum_phase_b, sum_motor;
    logic [CNT_BITS-1:0] calib_seen;
    logic [9:0]          offset_phase_b, offset_motor;
    logic                offsets_done;

    // Receiver hold-off
    int unsigned hold_left = 0;
    logic        hold_used = 1'b0;

    // Stretch of traffic with no idling on either side
    wire calm = (n_accepted >= 1000) && (n_accepted < 1200);

    adc_scan_smoothing_calibration DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_scan make_scan(logic [9:0] pb, logic [9:0] mc, logic [9:0] tp,
                                        logic [9:0] bv, logic [7:0] th, logic [7:0] br);
        t_scan s;
        s.phase_b_sample       = pb;
        s.motor_current_sample = mc;
        s.temperature_sample   = tp;
        s.battery_sample       = bv;
        s.throttle_sample      = th;
        s.brake_sample         = br;
        return s;
    endfunction

    // Clear the predicted filter and calibration state
    task automatic reset_predictor();
        calib_target = CAL_SCANS_RESET;
        for (int ch = 0; ch < NUM_FILT; ch++) begin
            filt_acc[ch] = '0;
            filt_out[ch] = '0;
        end
        scans_total    = '0;
        sum_phase_b    = '0;
        sum_motor      = '0;
        calib_seen     = '0;
        offset_phase_b = '0;
        offset_motor   = '0;
        offsets_done   = 1'b0;
    endtask

    // Advance the predictor by one scan and queue the result it gives
    task automatic predict_scan(input t_scan s);
        logic [9:0]  sample[NUM_FILT];
        int          shift;
        logic [ACC_BITS-1:0] acc;
        t_result     r;
        sample[CH_MOTOR] = s.motor_current_sample;
        sample[CH_TEMP]  = s.temperature_sample;
        sample[CH_BATT]  = s.battery_sample;
        sample[CH_THR]   = {2'b00, s.throttle_sample};
        sample[CH_BRK]   = {2'b00, s.brake_sample};
        for (int ch = 0; ch < NUM_FILT; ch++) begin
            shift = (ch == CH_MOTOR || ch == CH_TEMP) ? SLOW_SHIFT : FAST_SHIFT;
            acc = filt_acc[ch] - ACC_BITS'(filt_out[ch]) + ACC_BITS'(sample[ch]);
            filt_acc[ch] = acc;
            filt_out[ch] = 10'(acc >> shift);
            if (ch == CH_THR || ch == CH_BRK)
                filt_out[ch][9:8] = 2'b00;
        end
        scans_total = scans_total + 1'b1;

        // Offset calibration window
        if (!offsets_done) begin
            sum_phase_b = sum_phase_b + SUM_BITS'(s.phase_b_sample);
            sum_motor   = sum_motor + SUM_BITS'(s.motor_current_sample);
            calib_seen  = calib_seen + 1'b1;
            if (calib_seen >= calib_target && calib_seen != 0) begin
                offset_phase_b = 10'(sum_phase_b / SUM_BITS'(calib_seen));
                offset_motor   = 10'(sum_motor / SUM_BITS'(calib_seen));
                offsets_done   = 1'b1;
            end
        end

        r.phase_b_raw          = s.phase_b_sample;
        r.motor_current_raw    = s.motor_current_sample;
        r.motor_current_smooth = filt_out[CH_MOTOR];
        r.temperature_smooth   = filt_out[CH_TEMP];
        r.battery_smooth       = filt_out[CH_BATT];
        r.throttle_smooth      = filt_out[CH_THR][7:0];
        r.brake_smooth         = filt_out[CH_BRK][7:0];
        r.phase_b_offset       = offset_phase_b;
        r.motor_offset         = offset_motor;
        r.calib_done           = offsets_done;
        r.scan_count           = scans_total;
        expected_results.push_back(r);
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // Compare one result transaction with the oldest expectation
    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected");
            n_errors++;
        end else begin
            want = expected_results.pop_front();
            check_field("phase_b_raw", 16'(want.phase_b_raw), 16'(got.phase_b_raw));
            check_field("motor_current_raw", 16'(want.motor_current_raw),
                        16'(got.motor_current_raw));
            check_field("motor_current_smooth", 16'(want.motor_current_smooth),
                        16'(got.motor_current_smooth));
            check_field("temperature_smooth", 16'(want.temperature_smooth),
                        16'(got.temperature_smooth));
            check_field("battery_smooth", 16'(want.battery_smooth), 16'(got.battery_smooth));
            check_field("throttle_smooth", 16'(want.throttle_smooth),
                        16'(got.throttle_smooth));
            check_field("brake_smooth", 16'(want.brake_smooth), 16'(got.brake_smooth));
            check_field("phase_b_offset", 16'(want.phase_b_offset), 16'(got.phase_b_offset));
            check_field("motor_offset", 16'(want.motor_offset), 16'(got.motor_offset));
            check_field("calib_done", 16'(want.calib_done), 16'(got.calib_done));
            check_field("scan_count", want.scan_count, got.scan_count);
        end
    endtask

    // Monitor: config writes, accepted scans and results, all sampled at the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_predictor();
        end else begin
            if (cfg_valid && cfg_ready)
                calib_target = cfg_data;
            if (in_valid && !in_stall) begin
                predict_scan(in_data);
                n_accepted++;
            end
            if (out_valid && !out_stall) begin
                check_result(out_data);
                n_results++;
            end
        end
    end

    // Scan driver: payload holds while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pending_scans.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                in_data  <= pending_scans.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_used && n_results >= HOLD_AT_RESULT) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_scan(input t_scan s);
        pending_scans.push_back(s);
        n_queued++;
    endtask

    task automatic wait_drained(input int settle);
        while (n_results != n_queued)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_calib_scans(input logic [CNT_BITS-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Random scans: equal shares of slowly varying signals and full-range noise, plus rail values
    task automatic queue_random(input int count);
        t_scan base;
        t_scan s;
        int    pick;
        base = make_scan(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                         8'($urandom), 8'($urandom));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 5)
                base = make_scan(10'($urandom), 10'($urandom), 10'($urandom),
                                 10'($urandom), 8'($urandom), 8'($urandom));
            if (pick < 40) begin
                s = make_scan(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                              8'($urandom), 8'($urandom));
            end else if (pick < 80) begin
                s = make_scan(base.phase_b_sample + 10'($urandom_range(6)) - 10'd3,
                              base.motor_current_sample + 10'($urandom_range(6)) - 10'd3,
                              base.temperature_sample + 10'($urandom_range(6)) - 10'd3,
                              base.battery_sample + 10'($urandom_range(6)) - 10'd3,
                              base.throttle_sample + 8'($urandom_range(6)) - 8'd3,
                              base.brake_sample + 8'($urandom_range(6)) - 8'd3);
            end else begin
                s = make_scan($urandom_range(1) ? MAX10 : 10'd0,
                              $urandom_range(1) ? MAX10 : 10'd0,
                              $urandom_range(1) ? MAX10 : 10'd0,
                              $urandom_range(1) ? MAX10 : 10'd0,
                              $urandom_range(1) ? MAX8 : 8'd0,
                              $urandom_range(1) ? MAX8 : 8'd0);
            end
            queue_scan(s);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: rails, one field at a time, bit patterns, filter climb and decay
        queue_scan(make_scan(10'd0, 10'd0, 10'd0, 10'd0, 8'd0, 8'd0));
        queue_scan(make_scan(MAX10, MAX10, MAX10, MAX10, MAX8, MAX8));
        queue_scan(make_scan(MAX10, 10'd0, 10'd0, 10'd0, 8'd0, 8'd0));
        queue_scan(make_scan(10'd0, MAX10, 10'd0, 10'd0, 8'd0, 8'd0));
        queue_scan(make_scan(10'd0, 10'd0, MAX10, 10'd0, 8'd0, 8'd0));
        queue_scan(make_scan(10'd0, 10'd0, 10'd0, MAX10, 8'd0, 8'd0));
        queue_scan(make_scan(10'd0, 10'd0, 10'd0, 10'd0, MAX8, 8'd0));
        queue_scan(make_scan(10'd0, 10'd0, 10'd0, 10'd0, 8'd0, MAX8));
        queue_scan(make_scan(10'h2AA, 10'h2AA, 10'h2AA, 10'h2AA, 8'hAA, 8'hAA));
        queue_scan(make_scan(10'h155, 10'h155, 10'h155, 10'h155, 8'h55, 8'h55));
        repeat (8) queue_scan(make_scan(MAX10, MAX10, MAX10, MAX10, MAX8, MAX8));
        repeat (4) queue_scan(make_scan(10'd0, 10'd0, 10'd0, 10'd0, 8'd0, 8'd0));
        wait_drained(3);

        // Stretch the calibration window to its maximum and keep summing
        write_calib_scans(16'hFFFF);
        queue_random(200);
        wait_drained(3);

        // Zero is below the count reached: the next scan closes calibration
        write_calib_scans(16'd0);
        queue_random(700);
        wait_drained(3);

        // Writes after calibration is done must not change the offsets
        write_calib_scans(16'd1);
        queue_random(400);
        wait_drained(3);

        write_calib_scans(CAL_SCANS_RESET);
        queue_random(330);
        wait_drained(40);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ascs_pkg.sv
rtl/ascs_fifo.sv
rtl/ascs_front.sv
rtl/ascs_div.sv
rtl/ascs_back.sv
rtl/adc_scan_smoothing_calibration.sv
rtl/ascs_checker.sv
tb/tb_adc_scan_smoothing_calibration.sv
